FILE: rtl/core/polynomial_add_sub_mul_macros.svh
// Assertion macros shared by the polynomial block.
`ifndef POLYNOMIAL_ADD_SUB_MUL_MACROS_SVH
`define POLYNOMIAL_ADD_SUB_MUL_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define PASM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pasm: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define PASM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pasm: next-cycle check failed");

`endif

FILE: rtl/core/pasm_pkg.sv
// Package: field widths, defaults, kind codes and control structs of the polynomial block.
package pasm_pkg;

  localparam int unsigned NUM_TERMS_DEF = 25;
  localparam int unsigned COEF_BITS_DEF = 16;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned DEGREE_W = 6;
  localparam int unsigned SUM_W    = 17;
  localparam int unsigned DIFF_W   = 17;
  localparam int unsigned PROD_W   = 36;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  // Store write controls.
  typedef struct packed {
    logic we_a;
    logic we_b;
    logic clr;
  } pasm_wr_t;

  // One issued operation of the multiply-accumulate walk.
  typedef struct packed {
    logic valid;     // read pair issued
    logic start;     // clear accumulator for a new degree
    logic sum_diff;  // pair is A[d], B[d] for sum and difference
    logic last;      // last product pair of this degree
  } pasm_op_t;

endpackage

FILE: rtl/core/pasm_in_if.sv
// Input channel: command words with valid/ready handshake.
interface pasm_in_if import pasm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [INDEX_W-1:0]        term_index;
  logic signed [COEF_W-1:0]  coef_value;

  modport source (output valid, kind, term_index, coef_value, input ready);
  modport sink   (input valid, kind, term_index, coef_value, output ready);
endinterface

FILE: rtl/core/pasm_out_if.sv
// Output channel: per-degree result words with valid/ready handshake.
interface pasm_out_if import pasm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DEGREE_W-1:0]       degree;
  logic signed [SUM_W-1:0]   sum_term;
  logic signed [DIFF_W-1:0]  diff_term;
  logic signed [PROD_W-1:0]  product_term;
  logic                      last;

  modport source (output valid, degree, sum_term, diff_term, product_term, last,
                  input ready);
  modport sink   (input valid, degree, sum_term, diff_term, product_term, last,
                  output ready);
endinterface

FILE: rtl/core/pasm_mac.sv
// Coefficient stores and the shared read, multiply and accumulate pipeline.
module pasm_mac import pasm_pkg::*; #(
  parameter int unsigned NUM_TERMS = NUM_TERMS_DEF,
  parameter int unsigned COEF_BITS = COEF_BITS_DEF,
  localparam int unsigned AW = $clog2(NUM_TERMS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pasm_wr_t                     wr_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic signed [COEF_BITS-1:0]  wr_data_i,
  input  pasm_op_t                     op_i,
  input  logic [AW-1:0]                rd_i_i,
  input  logic [AW-1:0]                rd_j_i,
  output logic                         done_o,
  output logic signed [SUM_W-1:0]      sum_o,
  output logic signed [DIFF_W-1:0]     diff_o,
  output logic signed [PROD_W-1:0]     prod_o
);

  logic signed [COEF_BITS-1:0] mem_a [NUM_TERMS];
  logic signed [COEF_BITS-1:0] mem_b [NUM_TERMS];
  logic [NUM_TERMS-1:0]        vld_a_q, vld_b_q;

  logic signed [COEF_BITS-1:0] rd_a_q, rd_b_q;
  logic                        va_q, vb_q;
  pasm_op_t                    s1_q, s2_q;

  logic signed [COEF_BITS-1:0]   ma, mb;
  logic signed [2*COEF_BITS-1:0] pf;
  logic signed [32:0]            sa, sb;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [SUM_W-1:0]       sum_s2_q;
  logic signed [DIFF_W-1:0]      diff_s2_q;

  logic signed [PROD_W-1:0]      acc_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [DIFF_W-1:0]      diff_q;
  logic                          done_q;

  // store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_i.we_a) mem_a[wr_addr_i] <= wr_data_i;
    if (wr_i.we_b) mem_b[wr_addr_i] <= wr_data_i;
    rd_a_q <= mem_a[rd_i_i];
    rd_b_q <= mem_b[rd_j_i];
    va_q   <= vld_a_q[rd_i_i];
    vb_q   <= vld_b_q[rd_j_i];
  end

  // entry valid bits: unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
    end else if (wr_i.clr) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
    end else begin
      if (wr_i.we_a) vld_a_q[wr_addr_i] <= 1'b1;
      if (wr_i.we_b) vld_b_q[wr_addr_i] <= 1'b1;
    end
  end

  assign ma = va_q ? rd_a_q : '0;
  assign mb = vb_q ? rd_b_q : '0;
  assign pf = ma * mb;
  assign sa = 33'(ma);
  assign sb = 33'(mb);

  // multiply stage
  always_ff @(posedge clk_i) begin
    prod_q    <= PROD_W'(pf);
    sum_s2_q  <= SUM_W'(sa + sb);
    diff_s2_q <= DIFF_W'(sa - sb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= op_i;
      s2_q   <= s1_q;
      done_q <= s2_q.valid && s2_q.last;
    end
  end

  // accumulate stage
  always_ff @(posedge clk_i) begin
    if (op_i.start) begin
      acc_q  <= '0;
      sum_q  <= '0;
      diff_q <= '0;
    end else if (s2_q.valid) begin
      if (s2_q.sum_diff) begin
        sum_q  <= sum_s2_q;
        diff_q <= diff_s2_q;
      end else begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;
  assign diff_o = diff_q;
  assign prod_o = acc_q;

endmodule

FILE: rtl/core/polynomial_add_sub_mul.sv
// Top level: polynomial add, subtract and multiply over two coefficient stores.
//
// Input channel in_i carries command words: load A, load B, compute, clear.
// A load writes one coefficient (index NUM_TERMS or more is dropped); clear
// zeroes both stores. Load and clear give no output word.
// A compute word emits 2*NUM_TERMS-1 result words on out_o, degree 0 upward,
// each with A+B, A-B (zero above degree NUM_TERMS-1), the convolution term,
// and last set on the final degree.
// Compute walk: each degree d runs a setup step, a read of the A[d]/B[d]
// pair when d < NUM_TERMS, the product pairs in turn, a pipeline drain and
// an emit step. The walk is bound by the single shared multiplier and the
// one read port of each store. in_i is not ready during a compute run.
// Output stall: the result register holds its word until taken; the walk
// waits at each degree's emit step while the register is still full.
// Reset: both stores read as zero (per-entry valid bits cleared), the
// sequencer returns to idle and no output word is pending.
`include "polynomial_add_sub_mul_macros.svh"

module polynomial_add_sub_mul import pasm_pkg::*; #(
  parameter int unsigned NUM_TERMS = NUM_TERMS_DEF,
  parameter int unsigned COEF_BITS = COEF_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pasm_in_if.sink    in_i,
  pasm_out_if.source out_o
);

  localparam int unsigned AW    = $clog2(NUM_TERMS);
  localparam int unsigned DEG_W = $clog2(2*NUM_TERMS-1);
  localparam logic [DEG_W-1:0]    LAST_DEG     = DEG_W'(2*NUM_TERMS-2);
  localparam logic [DEG_W-1:0]    TERMS_DEG    = DEG_W'(NUM_TERMS);
  localparam logic [DEG_W-1:0]    TOP_TERM     = DEG_W'(NUM_TERMS-1);
  localparam logic [DEGREE_W-1:0] LAST_DEG_OUT = DEGREE_W'(2*NUM_TERMS-2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,   // clear accumulator, set first pair
    ST_SD,      // read A[d], B[d]
    ST_MAC,     // one product pair per cycle
    ST_DRAIN,   // wait for the pipeline to finish the degree
    ST_EMIT     // hand the degree to the output register
  } state_e;

  state_e           state_q;
  logic [DEG_W-1:0] deg_q, i_q;

  logic                       out_valid_q, out_last_q;
  logic [DEGREE_W-1:0]        out_deg_q;
  logic signed [SUM_W-1:0]    out_sum_q;
  logic signed [DIFF_W-1:0]   out_diff_q;
  logic signed [PROD_W-1:0]   out_prod_q;

  kind_e            in_kind;
  logic             in_accept, idx_ok, slot_free;
  logic             cmd_start;
  logic             deg_lt_n;
  logic [DEG_W-1:0] lo, hi, j_full;

  pasm_wr_t                    wr;
  pasm_op_t                    op;
  logic [AW-1:0]               rd_i, rd_j;
  logic                        dp_done;
  logic signed [SUM_W-1:0]     dp_sum;
  logic signed [DIFF_W-1:0]    dp_diff;
  logic signed [PROD_W-1:0]    dp_prod;

  assign in_kind   = kind_e'(in_i.kind);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept = in_i.valid && in_i.ready;
  assign cmd_start = in_accept && (in_kind == KIND_COMPUTE);
  assign idx_ok    = {2'b00, in_i.term_index} < 7'(NUM_TERMS);
  assign slot_free = !out_valid_q || out_o.ready;

  // store writes go straight to the datapath
  assign wr.we_a = in_accept && (in_kind == KIND_LOAD_A) && idx_ok;
  assign wr.we_b = in_accept && (in_kind == KIND_LOAD_B) && idx_ok;
  assign wr.clr  = in_accept && (in_kind == KIND_CLEAR);

  // pair range of the current degree: i in [lo, hi], j = d - i
  assign deg_lt_n = deg_q < TERMS_DEG;
  assign lo       = deg_lt_n ? '0 : deg_q - TOP_TERM;
  assign hi       = deg_lt_n ? deg_q : TOP_TERM;
  assign j_full   = deg_q - i_q;

  always_comb begin
    op   = '0;
    rd_i = i_q[AW-1:0];
    rd_j = j_full[AW-1:0];
    case (state_q)
      ST_START: op.start = 1'b1;
      ST_SD: begin
        op.valid    = 1'b1;
        op.sum_diff = 1'b1;
        rd_i        = deg_q[AW-1:0];
        rd_j        = deg_q[AW-1:0];
      end
      ST_MAC: begin
        op.valid = 1'b1;
        op.last  = (i_q == hi);
      end
      default: op = '0;
    endcase
  end

  pasm_mac #(
    .NUM_TERMS (NUM_TERMS),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_addr_i (AW'(in_i.term_index)),
    .wr_data_i (COEF_BITS'(in_i.coef_value)),
    .op_i      (op),
    .rd_i_i    (rd_i),
    .rd_j_i    (rd_j),
    .done_o    (dp_done),
    .sum_o     (dp_sum),
    .diff_o    (dp_diff),
    .prod_o    (dp_prod)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      deg_q       <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_deg_q   <= '0;
      out_sum_q   <= '0;
      out_diff_q  <= '0;
      out_prod_q  <= '0;
    end else begin
      if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_start) begin
            deg_q   <= '0;
            state_q <= ST_START;
          end
        end
        ST_START: begin
          i_q     <= lo;
          state_q <= deg_lt_n ? ST_SD : ST_MAC;
        end
        ST_SD: state_q <= ST_MAC;
        ST_MAC: begin
          if (i_q == hi) state_q <= ST_DRAIN;
          else           i_q     <= i_q + 1'b1;
        end
        ST_DRAIN: begin
          if (dp_done) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= (deg_q == LAST_DEG);
            out_deg_q   <= DEGREE_W'(deg_q);
            out_sum_q   <= dp_sum;
            out_diff_q  <= dp_diff;
            out_prod_q  <= dp_prod;
            if (deg_q == LAST_DEG) begin
              state_q <= ST_IDLE;
            end else begin
              deg_q   <= deg_q + 1'b1;
              state_q <= ST_START;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.degree       = out_deg_q;
  assign out_o.sum_term     = out_sum_q;
  assign out_o.diff_term    = out_diff_q;
  assign out_o.product_term = out_prod_q;
  assign out_o.last         = out_last_q;

  // pipeline finishes a degree only while the sequencer waits for it
  `PASM_ASSERT_SAME(a_done_in_drain, dp_done, state_q == ST_DRAIN)
  // a compute word starts the walk at degree zero
  `PASM_ASSERT_NEXT(a_compute_start, cmd_start, (state_q == ST_START) && (deg_q == '0))
  // the end marker rides only on the top degree
  `PASM_ASSERT_SAME(a_last_degree, out_o.valid && out_o.last, out_o.degree == LAST_DEG_OUT)
  // emit with a free slot always presents a word next cycle
  `PASM_ASSERT_NEXT(a_emit_loads, (state_q == ST_EMIT) && slot_free, out_o.valid)

endmodule
